[rtl/core/qsga_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qsga_pkg
// Shared types, constants and codes for the queued signal group arbiter.
// ----------------------------------------------------------------------------
package qsga_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_SIGNALS = 8;
    localparam int ID_WIDTH    = 16;
    localparam int TICK_W      = 31;
    localparam int TMO_W       = 16;
    localparam int GRANT_W     = TICK_W + 2;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int SIDX_W      = 3;

    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 40;

    typedef logic [ID_WIDTH-1:0]    id_t;
    typedef logic [TICK_W-1:0]      tick_t;
    typedef logic [TMO_W-1:0]       tmo_t;
    typedef logic [NUM_SIGNALS-1:0] sig_t;
    typedef logic [COUNT_W-1:0]     count_t;

    localparam logic signed [GRANT_W-1:0] GRANT_RESET = -GRANT_W'(10);
    localparam tmo_t                      TMO_RESET   = TMO_W'(5);
    localparam sig_t                      PRESENT_RESET = '1;

    typedef enum logic [1:0] {
        REQ_ADD     = 2'd0,
        REQ_PASS    = 2'd1,
        REQ_CLEAR   = 2'd2,
        REQ_REFRESH = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_IGNORED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PURGE,
        ST_OUT
    } state_t;

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_PRESENT = 1'b1;

    typedef struct packed {
        logic load;
        logic sync;
        logic mark;
        logic compact;
    } cell_cmd_t;

endpackage : qsga_pkg
`default_nettype wire

[rtl/core/qsga_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qsga_cell
// One queue entry: identifier, last-seen tick and expiry mark; takes its
// right neighbor's contents when the queue is compacted.
// ----------------------------------------------------------------------------
module qsga_cell
    import qsga_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_cmd_t cmd,
    input  wire logic      tail_sel,
    input  wire logic      occupied,
    input  wire id_t       req_id,
    input  wire tick_t     now,
    input  wire tmo_t      timeout,
    input  wire id_t       next_id,
    input  wire tick_t     next_time,
    input  wire logic      next_drop,
    input  wire logic      shift_in,
    output id_t            entry_id,
    output tick_t          entry_time,
    output logic           entry_drop,
    output logic           match,
    output logic           shift_out
);

    id_t   id_reg,   id_next;
    tick_t time_reg, time_next;
    logic  drop_reg, drop_next;
    logic  expired;
    logic signed [TICK_W:0] age;

    assign age     = $signed({1'b0, now}) - $signed({1'b0, time_reg});
    assign expired = occupied && (age > $signed({{(TICK_W + 1 - TMO_W){1'b0}}, timeout}));
    assign match   = occupied && (id_reg == req_id);
    assign shift_out = shift_in | drop_reg;

    always_comb
    begin
        id_next   = id_reg;
        time_next = time_reg;
        drop_next = drop_reg;
        if (cmd.load && tail_sel)
        begin
            id_next   = req_id;
            time_next = now;
        end
        if (cmd.sync && occupied)
        begin
            time_next = now;
        end
        if (cmd.mark)
        begin
            drop_next = expired;
        end
        if (cmd.compact && shift_out)
        begin
            id_next   = next_id;
            time_next = next_time;
            drop_next = next_drop;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        time_reg <= time_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_reg <= 1'b0;
        end
        else
        begin
            drop_reg <= drop_next;
        end
    end

    assign entry_id   = id_reg;
    assign entry_time = time_reg;
    assign entry_drop = drop_reg;

endmodule : qsga_cell
`default_nettype wire

[rtl/core/queued_signal_group_arbiter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// queued_signal_group_arbiter
// Grants a group of signals to requesters waiting in a first-in first-out
// queue held in a row of entry cells.
//
// Input stream (s_*): one word per request; s_tuser carries the request kind,
// s_tdata the requester, tick, direction mask and signal index. Output stream
// (m_*): one word per request with green/red masks, queue count, head
// identifier, grant flag and status. An APB port writes and reads the timeout
// and the present-signal mask.
//
// Add, pass, refresh and a clear at the previous clear's tick go from the
// execute state to the output state, which loads the result register. A clear
// at a new tick also passes through a purge state that removes one marked entry
// per cycle; no new request is taken until the block is back in idle.
// A result waiting in the output register does not block acceptance; the next
// result is held in the output stage, with s_tready low, until m_tready frees
// the register. Reset empties the queue, clears the movement mask and loads
// the register reset values; no entry memory is swept.
// ----------------------------------------------------------------------------
module queued_signal_group_arbiter
    import qsga_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // requester_id[15:0], now[46:16], direction_mask[54:47], signal_index[57:55]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // green_mask[7:0], red_mask[15:8], queue_count[20:16], head_id[36:21],
    // granted[37], status[39:38]
    output logic [OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    state_t    state_reg, state_next;
    req_type_t type_reg;
    id_t       id_reg;
    tick_t     now_reg;
    sig_t      dir_reg;
    logic [SIDX_W-1:0] sidx_reg;

    tmo_t   tmo_reg;
    sig_t   present_reg;
    count_t fill_reg, fill_next;
    logic signed [GRANT_W-1:0] lgt_reg, lgt_next;
    sig_t   mm_reg, mm_next;
    tick_t  lct_reg, lct_next;
    logic   granted_reg, granted_next;
    status_t status_reg, status_next;

    logic   out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    cell_cmd_t cmd;
    id_t   cell_id   [QUEUE_DEPTH];
    tick_t cell_time [QUEUE_DEPTH];
    logic  cell_drop [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_match;
    logic [QUEUE_DEPTH:0]   shift_chain;

    logic any_match;
    logic pass_expired;
    logic signed [GRANT_W:0] grant_age;
    logic out_free;
    logic cfg_write;
    sig_t green, red;
    id_t  head;

    assign shift_chain[0] = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        id_t   nid;
        tick_t ntime;
        logic  ndrop;
        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign nid   = '0;
            assign ntime = '0;
            assign ndrop = 1'b0;
        end
        else
        begin : g_mid
            assign nid   = cell_id[i+1];
            assign ntime = cell_time[i+1];
            assign ndrop = cell_drop[i+1];
        end
        qsga_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .tail_sel   (fill_reg == COUNT_W'(i)),
            .occupied   (COUNT_W'(i) < fill_reg),
            .req_id     (id_reg),
            .now        (now_reg),
            .timeout    (tmo_reg),
            .next_id    (nid),
            .next_time  (ntime),
            .next_drop  (ndrop),
            .shift_in   (shift_chain[i]),
            .entry_id   (cell_id[i]),
            .entry_time (cell_time[i]),
            .entry_drop (cell_drop[i]),
            .match      (cell_match[i]),
            .shift_out  (shift_chain[i+1])
        );
    end

    assign any_match = |cell_match;
    assign grant_age = $signed({3'b000, now_reg}) - $signed({lgt_reg[GRANT_W-1], lgt_reg});
    assign pass_expired = grant_age > $signed({{(GRANT_W + 1 - TMO_W){1'b0}}, tmo_reg});
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        lgt_next     = lgt_reg;
        mm_next      = mm_reg;
        lct_next     = lct_reg;
        granted_next = granted_reg;
        status_next  = status_reg;
        cmd          = '0;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        green = '0;
        red   = '0;
        head  = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next   = ST_EXEC;
                    granted_next = 1'b0;
                    status_next  = STAT_DONE;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_OUT;
                unique case (type_reg)
                    REQ_ADD:
                    begin
                        if (any_match)
                        begin
                            status_next = STAT_IGNORED;
                        end
                        else if (fill_reg >= COUNT_W'(QUEUE_DEPTH))
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            cmd.load  = 1'b1;
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    REQ_PASS:
                    begin
                        if (!any_match)
                        begin
                            status_next = STAT_IGNORED;
                        end
                        else if (cell_match[0])
                        begin
                            lgt_next     = $signed({2'b00, now_reg});
                            cmd.sync     = 1'b1;
                            mm_next      = dir_reg;
                            granted_next = 1'b1;
                        end
                        else if (pass_expired)
                        begin
                            lgt_next = $signed({2'b00, now_reg});
                            mm_next  = '0;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        if (lct_reg == now_reg)
                        begin
                            status_next = STAT_IGNORED;
                        end
                        else
                        begin
                            cmd.mark   = 1'b1;
                            lct_next   = now_reg;
                            state_next = ST_PURGE;
                        end
                    end
                    REQ_REFRESH:
                    begin
                        if (!cell_match[0] || !dir_reg[sidx_reg])
                        begin
                            status_next = STAT_IGNORED;
                        end
                        else
                        begin
                            lgt_next     = $signed({2'b00, now_reg});
                            mm_next      = dir_reg;
                            granted_next = 1'b1;
                        end
                    end
                endcase
            end
            ST_PURGE:
            begin
                cmd.compact = 1'b1;
                if (shift_chain[QUEUE_DEPTH])
                begin
                    fill_next = fill_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (fill_reg == '0)
                begin
                    green = present_reg;
                end
                else
                begin
                    green = mm_reg & present_reg;
                    red   = present_reg & ~mm_reg;
                    head  = cell_id[0];
                end
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {status_reg, granted_reg, head, fill_reg, red, green};
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            type_reg <= req_type_t'(s_tuser);
            id_reg   <= s_tdata[15:0];
            now_reg  <= s_tdata[46:16];
            dir_reg  <= s_tdata[54:47];
            sidx_reg <= s_tdata[57:55];
        end
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            lgt_reg       <= GRANT_RESET;
            mm_reg        <= '0;
            lct_reg       <= '0;
            granted_reg   <= 1'b0;
            status_reg    <= STAT_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            lgt_reg       <= lgt_next;
            mm_reg        <= mm_next;
            lct_reg       <= lct_next;
            granted_reg   <= granted_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tmo_reg     <= TMO_RESET;
            present_reg <= PRESENT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_TIMEOUT: tmo_reg     <= pwdata[TMO_W-1:0];
                REG_PRESENT: present_reg <= pwdata[NUM_SIGNALS-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_TIMEOUT: prdata = {{(32 - TMO_W){1'b0}}, tmo_reg};
            REG_PRESENT: prdata = {{(32 - NUM_SIGNALS){1'b0}}, present_reg};
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= COUNT_W'(QUEUE_DEPTH))
        else $error("queue fill above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PURGE |=> fill_reg <= $past(fill_reg))
        else $error("fill grew during purge");

    assert property (@(posedge clk) disable iff (!rst_n)
        granted_reg |-> status_reg == STAT_DONE)
        else $error("grant with non-done status");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[20:16] == '0) |-> m_tdata[15:8] == '0)
        else $error("red signals on empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_free) |=> m_tvalid)
        else $error("result not presented");

endmodule : queued_signal_group_arbiter
`default_nettype wire
